// ----- sv/msp_pkg.sv -----
`timescale 1ns / 1ps

package msp_pkg;

  // defaults for the top-level parameters
  localparam int CHANNELS_DEFAULT      = 4;
  localparam int GAIN_FRAC_DEFAULT     = 8;
  localparam int QUEUE_DEPTH           = 8;

  // field widths
  localparam int CH_W       = 2;
  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int ILIM_W     = 20;
  localparam int ERR_W      = 16;
  localparam int INTEG_W    = 21;
  localparam int DIFF_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd6;

  // reset values
  localparam logic [GAIN_W-1:0] KP_RESET        = 16'd1280;
  localparam logic [GAIN_W-1:0] KI_RESET        = 16'd0;
  localparam logic [GAIN_W-1:0] KD_RESET        = 16'd0;
  localparam logic [LIM_W-1:0]  ERR_LIMIT_RESET = 15'd5000;
  localparam logic [LIM_W-1:0]  DEAD_ZONE_RESET = 15'd0;
  localparam logic [ILIM_W-1:0] INT_LIMIT_RESET = 20'd5000;
  localparam logic [LIM_W-1:0]  OUT_LIMIT_RESET = 15'd5000;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]  error_limit;
    logic [LIM_W-1:0]  dead_zone;
    logic [ILIM_W-1:0] integral_limit;
    logic [LIM_W-1:0]  output_limit;
  } cfg_t;

  // state-update result handed to the gain path
  typedef struct packed {
    logic                      valid;
    logic [CH_W-1:0]           ch;
    logic signed [ERR_W-1:0]   e;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIFF_W-1:0]  d;
  } upd_t;

  typedef struct packed {
    logic                      valid;
    logic [CH_W-1:0]           ch;
    logic signed [SPEED_W-1:0] value;
  } res_t;

endpackage

// ----- sv/msp_cfg.sv -----
`timescale 1ns / 1ps

module msp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output msp_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp             <= msp_pkg::KP_RESET;
      cfg.ki             <= msp_pkg::KI_RESET;
      cfg.kd             <= msp_pkg::KD_RESET;
      cfg.error_limit    <= msp_pkg::ERR_LIMIT_RESET;
      cfg.dead_zone      <= msp_pkg::DEAD_ZONE_RESET;
      cfg.integral_limit <= msp_pkg::INT_LIMIT_RESET;
      cfg.output_limit   <= msp_pkg::OUT_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        msp_pkg::REG_KP:        cfg.kp             <= cfg_data[15:0];
        msp_pkg::REG_KI:        cfg.ki             <= cfg_data[15:0];
        msp_pkg::REG_KD:        cfg.kd             <= cfg_data[15:0];
        msp_pkg::REG_ERR_LIMIT: cfg.error_limit    <= cfg_data[14:0];
        msp_pkg::REG_DEAD_ZONE: cfg.dead_zone      <= cfg_data[14:0];
        msp_pkg::REG_INT_LIMIT: cfg.integral_limit <= cfg_data[19:0];
        msp_pkg::REG_OUT_LIMIT: cfg.output_limit   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/msp_state_update.sv -----
`timescale 1ns / 1ps

module msp_state_update #(
  parameter int CHANNELS = msp_pkg::CHANNELS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [msp_pkg::CH_W-1:0]            in_ch,
  input  logic signed [msp_pkg::SPEED_W-1:0]  in_target,
  input  logic signed [msp_pkg::SPEED_W-1:0]  in_measured,
  input  msp_pkg::cfg_t                       cfg,
  output msp_pkg::upd_t                       upd
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WORD_W = msp_pkg::INTEG_W + msp_pkg::ERR_W;

  // stage 1: error, clamp, dead zone; state read issued
  logic                               s1_valid;
  logic [msp_pkg::CH_W-1:0]           s1_ch;
  logic signed [msp_pkg::SPEED_W-1:0] s1_target;
  logic signed [msp_pkg::SPEED_W-1:0] s1_measured;

  logic signed [16:0] err_raw;
  logic signed [16:0] elim_pos;
  logic signed [16:0] elim_neg;
  logic signed [16:0] dz_pos;
  logic signed [16:0] dz_neg;
  logic signed [16:0] err_cl;
  logic signed [16:0] err_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_ch       <= in_ch;
    s1_target   <= in_target;
    s1_measured <= in_measured;
  end

  always_comb begin
    err_raw  = $signed({s1_target[15], s1_target}) - $signed({s1_measured[15], s1_measured});
    elim_pos = $signed({2'b00, cfg.error_limit});
    elim_neg = -elim_pos;
    dz_pos   = $signed({2'b00, cfg.dead_zone});
    dz_neg   = -dz_pos;
    if (err_raw > elim_pos) begin
      err_cl = elim_pos;
    end else if (err_raw < elim_neg) begin
      err_cl = elim_neg;
    end else begin
      err_cl = err_raw;
    end
    if ((err_cl > 17'sd0 && err_cl < dz_pos) || (err_cl < 17'sd0 && err_cl > dz_neg)) begin
      err_dz = 17'sd0;
    end else begin
      err_dz = err_cl;
    end
  end

  // per-channel state: {integral, previous error}
  logic [WORD_W-1:0]   mem [CHANNELS];
  logic [CHANNELS-1:0] ent_valid;
  logic [WORD_W-1:0]   rd_word;
  logic                rd_hit;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;

  // stage 2: read data back; integral and derivative; write back
  logic                               s2_valid;
  logic [msp_pkg::CH_W-1:0]           s2_ch;
  logic signed [msp_pkg::ERR_W-1:0]   s2_e;
  logic                               fwd;
  logic [WORD_W-1:0]                  wb_word;

  logic [WORD_W-1:0]                  old_word;
  logic signed [msp_pkg::INTEG_W-1:0] old_integ;
  logic signed [msp_pkg::ERR_W-1:0]   old_prev;
  logic signed [21:0]                 isum;
  logic signed [21:0]                 ilim_pos;
  logic signed [21:0]                 ilim_neg;
  logic signed [21:0]                 isum_cl;
  logic signed [msp_pkg::INTEG_W-1:0] integ_next;
  logic signed [msp_pkg::DIFF_W-1:0]  d_next;
  logic [WORD_W-1:0]                  word_next;

  assign rd_addr = AW'(s1_ch);
  assign wr_addr = AW'(s2_ch);

  always_ff @(posedge clk) begin
    rd_word <= mem[rd_addr];
    rd_hit  <= ent_valid[rd_addr];
    if (s2_valid) begin
      mem[wr_addr] <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      s2_valid  <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      if (s2_valid) begin
        ent_valid[wr_addr] <= 1'b1;
      end
    end
    s2_ch   <= s1_ch;
    s2_e    <= err_dz[15:0];
    // back-to-back items on one channel: the read above misses this write
    fwd     <= s2_valid && (s2_ch == s1_ch);
    wb_word <= word_next;
  end

  always_comb begin
    if (fwd) begin
      old_word = wb_word;
    end else if (rd_hit) begin
      old_word = rd_word;
    end else begin
      old_word = '0;
    end
    old_integ = $signed(old_word[WORD_W-1:msp_pkg::ERR_W]);
    old_prev  = $signed(old_word[msp_pkg::ERR_W-1:0]);
    isum      = $signed({old_integ[20], old_integ}) + $signed({{6{s2_e[15]}}, s2_e});
    ilim_pos  = $signed({2'b00, cfg.integral_limit});
    ilim_neg  = -ilim_pos;
    if (isum > ilim_pos) begin
      isum_cl = ilim_pos;
    end else if (isum < ilim_neg) begin
      isum_cl = ilim_neg;
    end else begin
      isum_cl = isum;
    end
    integ_next = isum_cl[msp_pkg::INTEG_W-1:0];
    d_next     = $signed({s2_e[15], s2_e}) - $signed({old_prev[15], old_prev});
    word_next  = {integ_next, s2_e};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd.valid <= 1'b0;
    end else begin
      upd.valid <= s2_valid;
    end
    upd.ch    <= s2_ch;
    upd.e     <= s2_e;
    upd.integ <= integ_next;
    upd.d     <= d_next;
  end

endmodule

// ----- sv/msp_gain_path.sv -----
`timescale 1ns / 1ps

module msp_gain_path #(
  parameter int GAIN_FRACTION_BITS = msp_pkg::GAIN_FRAC_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  msp_pkg::upd_t upd,
  input  msp_pkg::cfg_t cfg,
  output msp_pkg::res_t res
);

  localparam int SUM_W = 40;
  localparam logic [SUM_W-1:0] FRAC_MASK = (SUM_W'(1) << GAIN_FRACTION_BITS) - SUM_W'(1);

  // products
  logic                     p_valid;
  logic [msp_pkg::CH_W-1:0] p_ch;
  logic signed [32:0]       p_kp;
  logic signed [37:0]       p_ki;
  logic signed [33:0]       p_kd;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= upd.valid;
    end
    p_ch <= upd.ch;
    p_kp <= 33'($signed({1'b0, cfg.kp})) * 33'(upd.e);
    p_ki <= 38'($signed({1'b0, cfg.ki})) * 38'(upd.integ);
    p_kd <= 34'($signed({1'b0, cfg.kd})) * 34'(upd.d);
  end

  // exact sum
  logic                     s_valid;
  logic [msp_pkg::CH_W-1:0] s_ch;
  logic signed [SUM_W-1:0]  s_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= p_valid;
    end
    s_ch  <= p_ch;
    s_sum <= $signed({{7{p_kp[32]}}, p_kp}) + $signed({{2{p_ki[37]}}, p_ki})
           + $signed({{6{p_kd[33]}}, p_kd});
  end

  // scale toward zero, then output clamp
  logic signed [SUM_W-1:0] adj;
  logic signed [SUM_W-1:0] q;
  logic signed [SUM_W-1:0] olim_pos;
  logic signed [SUM_W-1:0] olim_neg;
  logic signed [SUM_W-1:0] q_cl;

  always_comb begin
    adj      = s_sum[SUM_W-1] ? (s_sum + $signed(FRAC_MASK)) : s_sum;
    q        = adj >>> GAIN_FRACTION_BITS;
    olim_pos = $signed({25'd0, cfg.output_limit});
    olim_neg = -olim_pos;
    if (q > olim_pos) begin
      q_cl = olim_pos;
    end else if (q < olim_neg) begin
      q_cl = olim_neg;
    end else begin
      q_cl = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= s_valid;
    end
    res.ch    <= s_ch;
    res.value <= q_cl[msp_pkg::SPEED_W-1:0];
  end

endmodule

// ----- sv/msp_out_queue.sv -----
`timescale 1ns / 1ps

module msp_out_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  msp_pkg::res_t                     res,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [msp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int PW = $clog2(msp_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(msp_pkg::QUEUE_DEPTH + 1);
  localparam int EW = msp_pkg::CH_W + msp_pkg::SPEED_W;

  logic [EW-1:0] q_mem [msp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;
  logic [EW-1:0] head;

  assign push = res.valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= {res.value, res.ch};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign head          = q_mem[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  // channel, value, high byte, low byte, zero pad
  assign m_axis_tdata  = {6'd0, head[9:2], head[17:10], head[17:2], head[1:0]};

endmodule

// ----- sv/motor_speed_pid_bank.sv -----
`timescale 1ns / 1ps

// Bank of per-channel speed PID controllers.
// s_axis: one beat per measurement: channel, target speed, measured speed and
//   a link-alive flag. A beat with the link down, or naming a channel beyond
//   CHANNELS, is taken and gives no result.
// m_axis: one beat per live measurement: channel, clamped drive value and the
//   two frame bytes of that value, in the order the measurements came in.
// cfg: write-only register port (index, data); always ready. Write gains and
//   limits only while the bank is idle.
// Throughput: one beat per cycle while s_axis_tready is high. Channel state
//   sits in a small synchronous memory that is read, updated and written back;
//   an item on the same channel right behind is served by a write-back bypass.
// Stall: results wait in an 8-deep queue. s_axis_tready drops only when
//   8 results are queued or in flight, so input keeps flowing while m_axis
//   is held.
// Reset: gains and limits take their defaults; per-channel valid flags clear
//   at once, so integral and previous error read as zero. No clearing pass.

module motor_speed_pid_bank #(
  parameter int CHANNELS           = msp_pkg::CHANNELS_DEFAULT,
  parameter int GAIN_FRACTION_BITS = msp_pkg::GAIN_FRAC_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] motor_index, [17:2] target_speed, [33:18] measured_speed,
  // [34] link_alive, [39:35] zero
  input  logic [msp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] channel, [17:2] drive_value, [25:18] drive_high_byte,
  // [33:26] drive_low_byte, [39:34] zero
  output logic [msp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CRW = $clog2(msp_pkg::QUEUE_DEPTH + 1);

  msp_pkg::cfg_t cfg;
  msp_pkg::upd_t upd;
  msp_pkg::res_t res;

  logic [msp_pkg::CH_W-1:0]           in_ch;
  logic signed [msp_pkg::SPEED_W-1:0] in_target;
  logic signed [msp_pkg::SPEED_W-1:0] in_measured;
  logic                               in_live;
  logic                               in_accept;
  logic                               in_live_item;
  logic                               out_beat;
  logic [CRW-1:0]                     in_flight;

  assign in_ch       = s_axis_tdata[1:0];
  assign in_target   = $signed(s_axis_tdata[17:2]);
  assign in_measured = $signed(s_axis_tdata[33:18]);
  assign in_live     = s_axis_tdata[34];

  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign in_live_item = in_accept && in_live && ({30'd0, in_ch} < 32'(CHANNELS));
  assign out_beat     = m_axis_tvalid && m_axis_tready;

  // credits: results queued or still in the pipe
  assign s_axis_tready = (in_flight < CRW'(msp_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      case ({in_live_item, out_beat})
        2'b10:   in_flight <= in_flight + CRW'(1);
        2'b01:   in_flight <= in_flight - CRW'(1);
        default: in_flight <= in_flight;
      endcase
    end
  end

  msp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msp_state_update #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_live_item),
    .in_ch       (in_ch),
    .in_target   (in_target),
    .in_measured (in_measured),
    .cfg         (cfg),
    .upd         (upd)
  );

  msp_gain_path #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_gain (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .cfg (cfg),
    .res (res)
  );

  msp_out_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- verif/motor_speed_pid_bank_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the speed PID bank.
// Input beats come from a queue filled by the stimulus block and are sent in
// bursts; the drive value expected for each live beat is computed at
// acceptance and compared with the m_axis beats in order.

module motor_speed_pid_bank_test;

  localparam int  GAIN_FRAC    = msp_pkg::GAIN_FRAC_DEFAULT;
  localparam int  NCH          = msp_pkg::CHANNELS_DEFAULT;
  localparam int  DRAIN_CYCLES = 16;        // keep a margin over the block latency
  localparam int  TIMEOUT_NS   = 4_000_000;
  localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;   // no register here

  // one speed measurement as sent on s_axis
  typedef struct packed {
    logic                               link;
    logic signed [msp_pkg::SPEED_W-1:0] measured;
    logic signed [msp_pkg::SPEED_W-1:0] target;
    logic [msp_pkg::CH_W-1:0]           motor;
  } speed_beat_t;

  // one drive beat as seen on m_axis
  typedef struct packed {
    logic [7:0]                         lo;
    logic [7:0]                         hi;
    logic signed [msp_pkg::SPEED_W-1:0] value;
    logic [msp_pkg::CH_W-1:0]           ch;
  } drive_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [1:0] motor_index, [17:2] target_speed, [33:18] measured_speed,
  // [34] link_alive, [39:35] zero
  logic [msp_pkg::IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [1:0] channel, [17:2] drive_value, [25:18] drive_high_byte,
  // [33:26] drive_low_byte, [39:34] zero
  logic [msp_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  motor_speed_pid_bank i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the controller: gains/limits and per-channel state
  // ---------------------------------------------------------------------------
  msp_pkg::cfg_t                      pid_regs;
  logic signed [msp_pkg::INTEG_W-1:0] integ_mem [NCH];
  logic signed [msp_pkg::ERR_W-1:0]   last_err  [NCH];

  speed_beat_t speed_pending [$];     // beats still to be sent
  drive_beat_t drive_expected [$];    // drive beats still owed by the block
  int          beats_queued = 0;
  int          beats_sent   = 0;
  int          fail_count   = 0;

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Full PID step for one live beat; updates the channel state.
  function automatic drive_beat_t predict_drive(input speed_beat_t b);
    longint      err;
    longint      integ;
    longint      diff;
    longint      sum;
    longint      q;
    longint      dz;
    drive_beat_t r;
    err = longint'(b.target) - longint'(b.measured);
    err = clamp_sym(err, longint'(pid_regs.error_limit));
    dz  = longint'(pid_regs.dead_zone);
    // dead zone is symmetric: |e| < dead_zone goes to zero on both sides
    if (err > 0 && err < dz) err = 0;
    if (err < 0 && err > -dz) err = 0;
    integ = clamp_sym(longint'(integ_mem[b.motor]) + err,
                      longint'(pid_regs.integral_limit));
    integ_mem[b.motor] = integ[msp_pkg::INTEG_W-1:0];
    diff = err - longint'(last_err[b.motor]);
    last_err[b.motor] = err[msp_pkg::ERR_W-1:0];
    sum = longint'(pid_regs.kp) * err + longint'(pid_regs.ki) * integ
        + longint'(pid_regs.kd) * diff;
    // drop the Q8.8 fraction, truncating toward zero
    if (sum < 0) q = -((-sum) >>> GAIN_FRAC);
    else         q = sum >>> GAIN_FRAC;
    q = clamp_sym(q, longint'(pid_regs.output_limit));
    r.ch    = b.motor;
    r.value = q[15:0];
    r.hi    = q[15:8];
    r.lo    = q[7:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  speed_beat_t beat_now;
  logic        beat_held  = 1'b0;
  int          burst_left = 0;
  int          gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      beat_held = 1'b0;
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (beat_now.link) drive_expected.push_back(predict_drive(beat_now));
        beats_sent++;
        beat_held = 1'b0;
      end
      if (!beat_held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (speed_pending.size() != 0) begin
          beat_now  = speed_pending.pop_front();
          beat_held = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; a quarter of them follow on with no gap at all
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      s_axis_tvalid <= beat_held;
      s_axis_tdata  <= {5'b0, beat_now};
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: ready follows a rotating stall pattern, reloaded now and then
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pat   = '0;
  int          pattern_age = 0;
  drive_beat_t drive_got;
  drive_beat_t drive_want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pat = '0;                            // no stalls
          1:       stall_pat = 16'($urandom);
          2:       stall_pat = 16'($urandom | $urandom);      // heavy back-pressure
          default: stall_pat = 16'($urandom & $urandom);
        endcase
      end
      pattern_age--;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      m_axis_tready <= !stall_pat[0];

      if (m_axis_tvalid && m_axis_tready) begin
        drive_got = m_axis_tdata[33:0];
        if (drive_expected.size() == 0) begin
          report_mismatch($sformatf("drive beat with none owed: ch %0d value %0d",
                                    drive_got.ch, drive_got.value));
        end else begin
          drive_want = drive_expected.pop_front();
          if (drive_got.ch !== drive_want.ch)
            report_mismatch($sformatf("channel %0d, expected %0d",
                                      drive_got.ch, drive_want.ch));
          if (drive_got.value !== drive_want.value)
            report_mismatch($sformatf("ch %0d drive_value %0d, expected %0d",
                                      drive_want.ch, drive_got.value, drive_want.value));
          if (drive_got.hi !== drive_want.hi)
            report_mismatch($sformatf("ch %0d drive_high_byte %02h, expected %02h",
                                      drive_want.ch, drive_got.hi, drive_want.hi));
          if (drive_got.lo !== drive_want.lo)
            report_mismatch($sformatf("ch %0d drive_low_byte %02h, expected %02h",
                                      drive_want.ch, drive_got.lo, drive_want.lo));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_beat(input int motor, input int target, input int measured,
                            input bit link);
    speed_beat_t b;
    b.motor    = motor[msp_pkg::CH_W-1:0];
    b.target   = target[msp_pkg::SPEED_W-1:0];
    b.measured = measured[msp_pkg::SPEED_W-1:0];
    b.link     = link;
    speed_pending.push_back(b);
    beats_queued++;
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  // n_live beats with the link up, plus link-down beats mixed in.
  // Half of all beats are near-misses, all with the link up: measured random, target within span.
  task automatic queue_random(input int n_live, input int span);
    int   live;
    int   pick;
    int   meas;
    int   tgt;
    int   ch;
    bit   lk;
    live = 0;
    ch   = 0;
    while (live < n_live) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0) ch = $urandom_range(0, NCH - 1);
      lk = (pick < 88);
      if (pick < 50) begin
        meas = int'($urandom_range(0, 65535)) - 32768;
        tgt  = meas + int'($urandom_range(0, 2 * span)) - span;
        if (tgt > 32767)  tgt = 32767;
        if (tgt < -32768) tgt = -32768;
      end else if (pick < 75 || pick >= 88) begin
        meas = int'($urandom_range(0, 65535)) - 32768;
        tgt  = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        meas = pick_extreme();
        tgt  = pick_extreme();
      end
      queue_beat(ch, tgt, meas, lk);
      if (lk) live++;
    end
  endtask

  // Wait until every beat is sent and every drive beat is back, then let the
  // pipeline run dry in case link-down beats are still inside.
  task automatic wait_idle();
    do begin
      while (beats_sent != beats_queued || drive_expected.size() != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end while (beats_sent != beats_queued || drive_expected.size() != 0);
  endtask

  task automatic write_reg(input logic [msp_pkg::CFG_IDX_W-1:0] idx,
                           input int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[msp_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      msp_pkg::REG_KP:        pid_regs.kp             = data[msp_pkg::GAIN_W-1:0];
      msp_pkg::REG_KI:        pid_regs.ki             = data[msp_pkg::GAIN_W-1:0];
      msp_pkg::REG_KD:        pid_regs.kd             = data[msp_pkg::GAIN_W-1:0];
      msp_pkg::REG_ERR_LIMIT: pid_regs.error_limit    = data[msp_pkg::LIM_W-1:0];
      msp_pkg::REG_DEAD_ZONE: pid_regs.dead_zone      = data[msp_pkg::LIM_W-1:0];
      msp_pkg::REG_INT_LIMIT: pid_regs.integral_limit = data[msp_pkg::ILIM_W-1:0];
      msp_pkg::REG_OUT_LIMIT: pid_regs.output_limit   = data[msp_pkg::LIM_W-1:0];
      default: ;     // unknown index: ignored
    endcase
  endtask

  task automatic write_all(input int kp, input int ki, input int kd, input int el,
                           input int dz, input int il, input int ol);
    write_reg(msp_pkg::REG_KP, kp);
    write_reg(msp_pkg::REG_KI, ki);
    write_reg(msp_pkg::REG_KD, kd);
    write_reg(msp_pkg::REG_ERR_LIMIT, el);
    write_reg(msp_pkg::REG_DEAD_ZONE, dz);
    write_reg(msp_pkg::REG_INT_LIMIT, il);
    write_reg(msp_pkg::REG_OUT_LIMIT, ol);
  endtask

  // Random settings; full 20-bit data so bits above each register get masked.
  task automatic write_random_cfg();
    write_reg(msp_pkg::REG_KP, $urandom);
    write_reg(msp_pkg::REG_KI,
              ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom);
    write_reg(msp_pkg::REG_KD, $urandom);
    write_reg(msp_pkg::REG_ERR_LIMIT, $urandom);
    write_reg(msp_pkg::REG_DEAD_ZONE,
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300));
    write_reg(msp_pkg::REG_INT_LIMIT, $urandom);
    write_reg(msp_pkg::REG_OUT_LIMIT, $urandom);
    write_reg(REG_SPARE, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    pid_regs.kp             = msp_pkg::KP_RESET;
    pid_regs.ki             = msp_pkg::KI_RESET;
    pid_regs.kd             = msp_pkg::KD_RESET;
    pid_regs.error_limit    = msp_pkg::ERR_LIMIT_RESET;
    pid_regs.dead_zone      = msp_pkg::DEAD_ZONE_RESET;
    pid_regs.integral_limit = msp_pkg::INT_LIMIT_RESET;
    pid_regs.output_limit   = msp_pkg::OUT_LIMIT_RESET;
    for (int c = 0; c < NCH; c++) begin
      integ_mem[c] = '0;
      last_err[c]  = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: error clamp both ways, zero error, link down
    queue_beat(0, 32767, -32768, 1);
    queue_beat(1, -32768, 32767, 1);
    queue_beat(2, 0, 0, 1);
    queue_beat(3, 100, 50, 1);
    queue_beat(0, 32767, -32768, 0);     // link down, no drive beat
    queue_beat(0, -1, 0, 1);
    queue_beat(1, 1, 0, 1);
    queue_beat(3, 0, 0, 0);
    queue_beat(3, -32768, -32768, 1);
    queue_beat(2, 32767, 32767, 1);
    queue_beat(0, 999, 0, 1);
    queue_beat(0, 1001, 0, 1);           // output clamp
    queue_random(140, 5100);
    wait_idle();

    // wide open limits, moderate gains
    write_all(256, 32, 128, 32767, 0, 1048575, 32767);
    queue_random(140, 32767);
    wait_idle();

    // gains at maximum
    write_all(65535, 65535, 65535, 32767, 100, 1048575, 32767);
    queue_random(140, 20000);
    wait_idle();

    // every limit zero: all drive values forced to zero
    write_all(40000, 1000, 65535, 0, 0, 0, 0);
    queue_random(140, 1000);
    wait_idle();

    // dead zone on both sides of zero, plus truncation of a negative sum
    write_all(385, 16, 64, 5000, 1000, 20000, 10000);
    queue_beat(0, 999, 0, 1);
    queue_beat(0, 1000, 0, 1);
    queue_beat(1, -999, 0, 1);
    queue_beat(1, -1000, 0, 1);
    queue_beat(2, 0, 1001, 1);
    queue_beat(3, -11, 0, 1);
    queue_random(140, 2100);
    wait_idle();

    // dead zone at its top: only a fully clamped error gets through
    write_all(300, 200, 100, 32767, 32767, 500000, 32767);
    queue_random(140, 32767);
    wait_idle();

    // random settings, twice over; the spare index is written as well
    write_random_cfg();
    queue_random(140, pid_regs.error_limit + pid_regs.dead_zone + 64);
    wait_idle();
    write_random_cfg();
    queue_random(140, pid_regs.error_limit + pid_regs.dead_zone + 64);
    wait_idle();

    // smallest non-zero limits under the largest gains
    write_all(65535, 65535, 65535, 1, 0, 1, 1);
    queue_random(150, 8);
    wait_idle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
